>>> src/qgpt_pkg.sv
// ----------------------------------------------------------------------------
// qgpt_pkg: shared definitions for the quiescent grace period tracker
// Widths, slot count, request and status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package qgpt_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEQ_W   = 64;
  localparam int STEP_W  = 11;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register numbers, taken from the word address bit of paddr.
  localparam logic REG_SEQ_STEP = 1'b0;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2);
  localparam logic [SEQ_W-1:0]  SEQ_RESET  = SEQ_W'(1);

  typedef enum logic [1:0] {
    REQ_ATTACH  = 2'd0,
    REQ_DETACH  = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_POLL    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ATTACHED = 2'd1,
    STAT_DETACHED = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_SCAN,
    ST_FOLD,
    ST_ANSWER
  } state_t;

endpackage

`default_nettype wire

>>> src/quiescent_grace_period_tracker.sv
// ----------------------------------------------------------------------------
// quiescent_grace_period_tracker: sequence based grace period tracker
// Keeps a write sequence, a read sequence and one sequence per thread slot.
// Polls fold the wrap-aware minimum of all online slots into the read
// sequence using one shared 64-bit subtract-and-compare unit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                        Payload
//  --------  -------------------------------  ----------------------------------
//  request   start & !busy                    in_req_type, in_slot, in_goal
//  result    out_valid (one cycle, no stall)  out_goal_reached, out_seq_value,
//                                             out_status
//  config    psel & penable & pwrite & pready paddr, pwdata (prdata on reads)
//
// An advance, an attach or detach of a slot beyond the slot table, and a
// poll whose goal is already reached answer in the cycle after the accept,
// and the block can take the next beat at once. An attach or detach in
// range reads the slot memory first, so busy stays high through ST_SLOT
// and the answer is registered from there. A poll that must scan keeps
// busy high through ST_SCAN, ST_FOLD and ST_ANSWER: one memory read per
// slot through the scan loop, then a fold of the minimum into the read
// sequence and a test of the goal, all on the same compare unit.
// Reset is synchronous (rst_n low) and takes effect at once; slot valid bits
// are cleared in that same edge, so no clearing pass is needed.
// The result receiver cannot stall: each result shows for exactly one cycle.
//
`default_nettype none

module quiescent_grace_period_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic [5:0]                     in_slot,
  input  wire logic [qgpt_pkg::SEQ_W-1:0]     in_goal,
  // result channel
  output logic                                out_valid,
  output logic                                out_goal_reached,
  output logic [qgpt_pkg::SEQ_W-1:0]          out_seq_value,
  output logic [1:0]                          out_status,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [qgpt_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [qgpt_pkg::CFG_DW-1:0]    pwdata,
  output logic [qgpt_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  import qgpt_pkg::*;

  // Sequencer and datapath registers.
  state_t                state_r, state_nxt;
  req_t                  req_r, req_nxt;
  logic [SLOT_AW-1:0]    slot_r, slot_nxt;
  logic [SLOT_AW-1:0]    idx_r, idx_nxt;
  logic [SEQ_W-1:0]      goal_r, goal_nxt;
  logic [SEQ_W-1:0]      low_r, low_nxt;
  logic [SEQ_W-1:0]      write_seq_r, write_seq_nxt;
  logic [SEQ_W-1:0]      read_seq_r, read_seq_nxt;
  logic [STEP_W-1:0]     seq_step_r;

  // Result registers.
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_reached_r, out_reached_nxt;
  logic [SEQ_W-1:0]      out_value_r, out_value_nxt;
  stat_t                 out_status_r, out_status_nxt;

  // Slot sequence memory plus one valid bit per entry; an entry whose valid
  // bit is clear reads as zero, which is the offline sequence.
  logic [SEQ_W-1:0]      seq_mem [SLOTS];
  logic [SLOTS-1:0]      vld_r, vld_nxt;
  logic [SEQ_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic                  mem_we;
  logic [SLOT_AW-1:0]    mem_waddr;
  logic [SEQ_W-1:0]      mem_wdata;
  logic [SLOT_AW-1:0]    mem_raddr;
  logic [SEQ_W-1:0]      entry;

  // The one shared compare unit: a - b taken as a two's complement value.
  logic [SEQ_W-1:0]      cmp_a, cmp_b, cmp_diff;
  logic                  cmp_lt, cmp_le;

  logic                  accept;
  logic                  slot_ok;
  logic                  cfg_wr;

  assign cmp_diff = cmp_a - cmp_b;
  assign cmp_lt   = cmp_diff[SEQ_W-1];
  assign cmp_le   = cmp_lt || (cmp_diff == '0);

  assign accept  = start && !busy;
  assign slot_ok = (32'(in_slot) < SLOTS);
  assign entry   = rd_vld_r ? rd_data_r : '0;

  // Configuration port. Only the word address bit selects a register, so a
  // write to any other word is dropped.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SEQ_STEP) ? CFG_DW'(seq_step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_step_r <= STEP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_SEQ_STEP)) begin
      seq_step_r <= pwdata[STEP_W-1:0];
    end
  end

  // Next state, datapath and result logic.
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    slot_nxt        = slot_r;
    idx_nxt         = idx_r;
    goal_nxt        = goal_r;
    low_nxt         = low_r;
    write_seq_nxt   = write_seq_r;
    read_seq_nxt    = read_seq_r;
    vld_nxt         = vld_r;
    out_valid_nxt   = 1'b0;
    out_reached_nxt = out_reached_r;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_waddr       = slot_r;
    mem_wdata       = write_seq_r;
    mem_raddr       = SLOT_AW'(in_slot);
    cmp_a           = in_goal;
    cmp_b           = read_seq_r;
    busy            = 1'b1;

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          req_nxt  = req_t'(in_req_type);
          slot_nxt = SLOT_AW'(in_slot);
          goal_nxt = in_goal;
          case (req_t'(in_req_type))
            REQ_ATTACH, REQ_DETACH: begin
              if (slot_ok) begin
                state_nxt = ST_SLOT;
              end else begin
                out_valid_nxt   = 1'b1;
                out_reached_nxt = 1'b0;
                out_value_nxt   = '0;
                out_status_nxt  = STAT_OK;
              end
            end
            REQ_ADVANCE: begin
              write_seq_nxt   = write_seq_r + SEQ_W'(seq_step_r);
              out_valid_nxt   = 1'b1;
              out_reached_nxt = 1'b0;
              out_value_nxt   = write_seq_nxt;
              out_status_nxt  = STAT_OK;
            end
            REQ_POLL: begin
              // Goal already covered by the read sequence: answer at once.
              if (cmp_le) begin
                out_valid_nxt   = 1'b1;
                out_reached_nxt = 1'b1;
                out_value_nxt   = read_seq_r;
                out_status_nxt  = STAT_OK;
              end else begin
                mem_raddr = '0;
                idx_nxt   = '0;
                low_nxt   = write_seq_r;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SLOT: begin
        out_valid_nxt   = 1'b1;
        out_reached_nxt = 1'b0;
        out_status_nxt  = STAT_OK;
        state_nxt       = ST_IDLE;
        if (req_r == REQ_ATTACH) begin
          if (entry != '0) begin
            out_status_nxt = STAT_ATTACHED;
            out_value_nxt  = entry;
          end else begin
            mem_we          = 1'b1;
            vld_nxt[slot_r] = 1'b1;
            out_value_nxt   = write_seq_r;
          end
        end else begin
          out_value_nxt = '0;
          if (entry == '0) begin
            out_status_nxt = STAT_DETACHED;
          end else begin
            vld_nxt[slot_r] = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // Entry idx_r is in the read register; fetch the next one meanwhile.
        cmp_a     = entry;
        cmp_b     = low_r;
        mem_raddr = idx_r + SLOT_AW'(1);
        if ((entry != '0) && cmp_lt) begin
          low_nxt = entry;
        end
        if (idx_r == SLOT_AW'(SLOTS - 1)) begin
          state_nxt = ST_FOLD;
        end else begin
          idx_nxt = idx_r + SLOT_AW'(1);
        end
      end

      ST_FOLD: begin
        cmp_a = read_seq_r;
        cmp_b = low_r;
        if (cmp_lt) begin
          read_seq_nxt = low_r;
        end
        state_nxt = ST_ANSWER;
      end

      ST_ANSWER: begin
        cmp_a           = goal_r;
        cmp_b           = read_seq_r;
        out_valid_nxt   = 1'b1;
        out_reached_nxt = cmp_le;
        out_value_nxt   = read_seq_r;
        out_status_nxt  = STAT_OK;
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      write_seq_r <= SEQ_RESET;
      read_seq_r  <= SEQ_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      write_seq_r <= write_seq_nxt;
      read_seq_r  <= read_seq_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    slot_r        <= slot_nxt;
    idx_r         <= idx_nxt;
    goal_r        <= goal_nxt;
    low_r         <= low_nxt;
    out_reached_r <= out_reached_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Slot sequence memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= seq_mem[mem_raddr];
    rd_vld_r  <= vld_r[mem_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_goal_reached = out_reached_r;
  assign out_seq_value    = out_value_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

>>> tb/grace_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grace_check_pkg: expected-answer tracking for the grace period tracker
// Mirrors the slot table and the write and read sequences, works out the
// answer to every accepted request and checks returned answers in order.
// ----------------------------------------------------------------------------

package grace_check_pkg;

  import qgpt_pkg::*;

  typedef struct {
    logic              reached;
    logic [SEQ_W-1:0]  value;
    stat_t             status;
  } grace_answer_t;

  class grace_tracker_model;

    logic [SEQ_W-1:0]  slot_seq [SLOTS];
    logic [SEQ_W-1:0]  write_seq;
    logic [SEQ_W-1:0]  read_seq;
    logic [STEP_W-1:0] seq_step;
    grace_answer_t     answers_due [$];
    int                errors;

    function new();
      foreach (slot_seq[i]) slot_seq[i] = '0;
      write_seq = SEQ_RESET;
      read_seq  = SEQ_RESET;
      seq_step  = STEP_RESET;
      errors    = 0;
    endfunction

    // Wrap-aware ordering: a is older than b when a - b is negative.
    static function logic seq_before(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
    endfunction

    static function logic seq_not_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return (diff == '0) || diff[SEQ_W-1];
    endfunction

    function void note_request(req_t req, logic [5:0] slot, logic [SEQ_W-1:0] goal);
      grace_answer_t ans;
      logic [SEQ_W-1:0] low;
      ans = '{reached: 1'b0, value: '0, status: STAT_OK};
      case (req)
        REQ_ATTACH: begin
          if (slot < SLOTS) begin
            if (slot_seq[slot] != '0) begin
              ans.status = STAT_ATTACHED;
            end else begin
              slot_seq[slot] = write_seq;
            end
            ans.value = slot_seq[slot];
          end
        end
        REQ_DETACH: begin
          if (slot < SLOTS) begin
            if (slot_seq[slot] == '0) begin
              ans.status = STAT_DETACHED;
            end else begin
              slot_seq[slot] = '0;
            end
          end
        end
        REQ_ADVANCE: begin
          write_seq = write_seq + SEQ_W'(seq_step);
          ans.value = write_seq;
        end
        default: begin
          if (seq_not_after(goal, read_seq)) begin
            ans.reached = 1'b1;
          end else begin
            low = write_seq;
            foreach (slot_seq[i]) begin
              if (slot_seq[i] != '0 && seq_before(slot_seq[i], low)) low = slot_seq[i];
            end
            if (seq_before(read_seq, low)) read_seq = low;
            ans.reached = seq_not_after(goal, read_seq);
          end
          ans.value = read_seq;
        end
      endcase
      answers_due.push_back(ans);
    endfunction

    function void check_answer(logic reached, logic [SEQ_W-1:0] value, logic [1:0] status);
      grace_answer_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: answer beat with none outstanding (reached %0b value %h status %0d)",
                 $time, reached, value, status);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (reached !== want.reached) begin
        $display("%0t: goal_reached expected %0b actual %0b", $time, want.reached, reached);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: seq_value expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction

  endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for quiescent_grace_period_tracker
// Drives attach, detach, advance and poll requests through the start/busy
// channel, changes the step register over APB between phases, and checks
// every answer beat against a predicted copy of the tracker state.
// ----------------------------------------------------------------------------

module testbench;

  import qgpt_pkg::*;
  import grace_check_pkg::*;

  // Even with scanning polls and long sender gaps, a correct run of about
  // two thousand requests stays far below this limit.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam logic [CFG_AW-1:0] STEP_ADDR = CFG_AW'(4 * REG_SEQ_STEP);
  localparam logic [SEQ_W-1:0] HALF_RANGE = {1'b1, {(SEQ_W-1){1'b0}}};
  localparam int PHASE_BEATS = 630;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type = REQ_ATTACH;
  logic [5:0]           in_slot = '0;
  logic [SEQ_W-1:0]     in_goal = '0;
  logic                 out_valid;
  logic                 out_goal_reached;
  logic [SEQ_W-1:0]     out_seq_value;
  logic [1:0]           out_status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  grace_tracker_model   model;
  int                   idle_pct = 0;
  int                   cycle_count = 0;

  quiescent_grace_period_tracker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_slot          (in_slot),
    .in_goal          (in_goal),
    .out_valid        (out_valid),
    .out_goal_reached (out_goal_reached),
    .out_seq_value    (out_seq_value),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Watchdog. A hung handshake or a lost answer ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Answers cannot be held off, so every strobed cycle is one answer beat.
  // Outputs are read at the edge that ends the cycle, before any update.
  always @(posedge clk) begin
    if (rst_n && out_valid) model.check_answer(out_goal_reached, out_seq_value, out_status);
  end

  // Presents one request and returns at the edge that accepts it. The
  // expected answer is worked out right there, so any goal picked by the
  // caller afterwards sees the state as the block has it. start is left
  // high on return; the next call either overwrites the payload in the same
  // step or drops start while the sender idles.
  task automatic send_request(input req_t req, input logic [5:0] slot,
                              input logic [SEQ_W-1:0] goal);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_slot     <= slot;
    in_goal     <= goal;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.note_request(req, slot, goal);
  endtask

  // Step register update. Only done once every outstanding answer is back
  // and the block is not busy; each request answers exactly once, so at
  // that point the block has nothing in flight. The value is read back.
  task automatic write_step(input logic [STEP_W-1:0] value);
    logic [CFG_DW-1:0] readback;
    start <= 1'b0;
    @(posedge clk);
    while (model.answers_due.size() != 0 || busy) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STEP_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model.seq_step = value;
    // Read back: psel stays high, so this cycle is the setup of the read.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[STEP_W-1:0] !== value) begin
      $display("%0t: seq_step readback expected %h actual %h", $time, value,
               readback[STEP_W-1:0]);
      model.errors++;
    end
  endtask

  // Goals cluster around the live sequences so that polls land on both
  // sides of the read sequence, with a share of fully random values and
  // values half the sequence space away where the wrap-aware compare flips.
  function automatic logic [SEQ_W-1:0] pick_goal();
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return model.read_seq + SEQ_W'($urandom_range(128)) - SEQ_W'(64);
      2: return model.write_seq - SEQ_W'($urandom_range(4096));
      3: return model.write_seq + SEQ_W'($urandom_range(64));
      default: return model.read_seq + HALF_RANGE - SEQ_W'($urandom_range(1));
    endcase
  endfunction

  // Mostly a crowded handful of low slots, so repeated attaches and
  // detaches hit the error cases often, plus the whole slot range.
  task automatic random_requests(input int count);
    int pick;
    req_t req;
    logic [5:0] slot;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 20) req = REQ_ATTACH;
      else if (pick < 45) req = REQ_DETACH;
      else if (pick < 65) req = REQ_ADVANCE;
      else req = REQ_POLL;
      slot = ($urandom_range(1) == 1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      send_request(req, slot, pick_goal());
    end
  endtask

  initial begin
    model = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the step at its reset value. Goal 0 and
    // goal 1 are already reached; goal 2 needs a scan of an empty table.
    send_request(REQ_POLL, 6'd0, '0);
    send_request(REQ_POLL, 6'd0, SEQ_W'(1));
    send_request(REQ_POLL, 6'd0, SEQ_W'(2));
    // Attach twice to the same slot: the second one is refused.
    send_request(REQ_ATTACH, 6'd0, '0);
    send_request(REQ_ATTACH, 6'd0, '0);
    send_request(REQ_ADVANCE, 6'd0, '0);
    send_request(REQ_ATTACH, 6'd63, '0);
    send_request(REQ_ADVANCE, 6'd63, '1);
    // Slot 0 still holds the oldest sequence, so this poll falls short.
    send_request(REQ_POLL, 6'd0, model.write_seq);
    // Detach twice: the second one finds the slot already offline.
    send_request(REQ_DETACH, 6'd0, '0);
    send_request(REQ_DETACH, 6'd0, '0);
    send_request(REQ_POLL, 6'd63, model.slot_seq[63]);
    send_request(REQ_DETACH, 6'd63, '0);
    send_request(REQ_POLL, 6'd0, model.write_seq);
    // The all-ones goal counts as behind the read sequence.
    send_request(REQ_POLL, 6'd0, '1);
    // Exactly half the space ahead reads as behind; one less is ahead.
    send_request(REQ_POLL, 6'd0, model.read_seq + HALF_RANGE);
    send_request(REQ_POLL, 6'd0, model.read_seq + HALF_RANGE - SEQ_W'(1));

    // A zero step leaves the write sequence where it is.
    write_step('0);
    send_request(REQ_ADVANCE, 6'd1, '0);
    send_request(REQ_ATTACH, 6'd5, '0);
    write_step('1);
    send_request(REQ_ADVANCE, 6'd2, '0);
    send_request(REQ_POLL, 6'd5, model.write_seq);
    send_request(REQ_DETACH, 6'd5, '0);
    send_request(REQ_POLL, 6'd5, model.write_seq);

    // Random phases, each with its own step and sender idle share.
    write_step(STEP_W'(1024));
    idle_pct = 8;
    random_requests(PHASE_BEATS);

    write_step(STEP_W'(1));
    idle_pct = 87;
    random_requests(PHASE_BEATS);

    write_step(STEP_W'($urandom_range(2047)));
    idle_pct = 0;
    random_requests(PHASE_BEATS);

    start <= 1'b0;
    @(posedge clk);
    while (model.answers_due.size() != 0) @(posedge clk);
    // Quiet stretch to catch any stray answer beat.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (model.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> quiescent_grace_period_tracker.f
src/qgpt_pkg.sv
src/quiescent_grace_period_tracker.sv
tb/grace_check_pkg.sv
tb/testbench.sv
